// ===== src/assert_macros.svh =====
// Assertion macros for the hash table RTL.
// Define NO_ASSERTIONS to compile them out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DPHT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
`define DPHT_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define DPHT_ASSERT(lbl, clk, rstn, prop, msg)
`define DPHT_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

// ===== src/dpht_pkg.sv =====
// Shared types, constants and microcode ROM for the dual probing hash table.
// No dependencies.
`timescale 1ns / 1ps

package dpht_pkg;

    localparam int TABLE_LOG2 = 3;
    localparam int TABLE_SIZE = 1 << TABLE_LOG2;
    localparam int SLOT_W     = TABLE_LOG2;
    localparam int STEP_W     = TABLE_LOG2 + 1;
    localparam int KEY_BITS   = 34;
    localparam int COUNT_W    = 4;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    // microcode step addresses
    localparam int UPC_W = 2;
    typedef logic [UPC_W-1:0] upc_t;
    localparam upc_t UPC_ACCEPT = 2'd0;
    localparam upc_t UPC_PROBE  = 2'd1;
    localparam upc_t UPC_EMIT   = 2'd2;

    typedef enum logic [1:0] {
        COND_IN_VALID = 2'd0,
        COND_DONE     = 2'd1,
        COND_OUT_FREE = 2'd2
    } cond_t;

    typedef struct packed {
        logic  accept_act;
        logic  probe_act;
        logic  emit_act;
        cond_t cond;
        upc_t  target;
    } ucode_t;

    // sequencer -> datapath strobes
    typedef struct packed {
        logic accept;
        logic probe;
        logic emit;
    } seq_ctrl_t;

    // probe unit -> top
    typedef struct packed {
        logic                done_next;
        status_t             status;
        logic [COUNT_W-1:0]  count;
    } probe_res_t;

    // Control program: jump to target when cond holds, else stay on the step.
    function automatic ucode_t ucode_rom(input upc_t upc);
        ucode_t cw;
        case (upc)
            UPC_ACCEPT: cw = '{accept_act: 1'b1, probe_act: 1'b0, emit_act: 1'b0,
                               cond: COND_IN_VALID, target: UPC_PROBE};
            UPC_PROBE:  cw = '{accept_act: 1'b0, probe_act: 1'b1, emit_act: 1'b0,
                               cond: COND_DONE, target: UPC_EMIT};
            UPC_EMIT:   cw = '{accept_act: 1'b0, probe_act: 1'b0, emit_act: 1'b1,
                               cond: COND_OUT_FREE, target: UPC_ACCEPT};
            default:    cw = '{accept_act: 1'b0, probe_act: 1'b0, emit_act: 1'b0,
                               cond: COND_IN_VALID, target: UPC_ACCEPT};
        endcase
        return cw;
    endfunction

endpackage

// ===== src/dual_probing_hash_table.sv =====
// Dual open-addressing hash table (8 slots each): every transaction inserts or
// searches a 34-bit key in a linear-probing and a quadratic-probing table at once.
// A transaction runs one accept step, one probe step per slot examined (1 to 8,
// both tables probed in parallel, the probe step is left only when both tables
// are done) and one step to load the output register, which presents the result.
// in_stall is low only in the accept step. The load step waits while an earlier
// result is still held under out_stall; the next transaction can be taken in the
// cycle after the result is loaded. Counts report slots probed on insert and
// keys compared on search; status 2 means no free slot was reached within 8 probes.
// Depends on dpht_pkg, dpht_seq, dpht_probe and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dual_probing_hash_table (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [dpht_pkg::KEY_BITS-1:0] key,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [1:0]                    linear_status,
    output logic [dpht_pkg::COUNT_W-1:0]  linear_count,
    output logic [1:0]                    quadratic_status,
    output logic [dpht_pkg::COUNT_W-1:0]  quadratic_count
);

    dpht_pkg::seq_ctrl_t  ctrl;
    dpht_pkg::probe_res_t lin_res, quad_res;

    logic [dpht_pkg::KEY_BITS-1:0] key_reg;
    logic                          search_reg;
    logic                          out_free;
    logic                          out_valid_reg, out_valid_next;
    logic [1:0]                    lin_status_reg, quad_status_reg;
    logic [dpht_pkg::COUNT_W-1:0]  lin_count_reg, quad_count_reg;
    logic [2:0]                    strobes;
    logic                          counts_in_range;

    assign out_free = ~out_valid_reg | ~out_stall;

    dpht_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .probes_done (lin_res.done_next & quad_res.done_next),
        .out_free    (out_free),
        .in_stall    (in_stall),
        .ctrl        (ctrl)
    );

    dpht_probe u_lin (
        .clk    (clk),
        .rst_n  (rst_n),
        .quad   (1'b0),
        .ctrl   (ctrl),
        .search (search_reg),
        .in_key (key),
        .key_q  (key_reg),
        .res    (lin_res)
    );

    dpht_probe u_quad (
        .clk    (clk),
        .rst_n  (rst_n),
        .quad   (1'b1),
        .ctrl   (ctrl),
        .search (search_reg),
        .in_key (key),
        .key_q  (key_reg),
        .res    (quad_res)
    );

    always_comb
    begin
        if (ctrl.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.accept)
        begin
            key_reg    <= key;
            search_reg <= operation;
        end
        if (ctrl.emit)
        begin
            lin_status_reg  <= lin_res.status;
            lin_count_reg   <= lin_res.count;
            quad_status_reg <= quad_res.status;
            quad_count_reg  <= quad_res.count;
        end
    end

    assign out_valid        = out_valid_reg;
    assign linear_status    = lin_status_reg;
    assign linear_count     = lin_count_reg;
    assign quadratic_status = quad_status_reg;
    assign quadratic_count  = quad_count_reg;

    assign strobes         = {ctrl.accept, ctrl.probe, ctrl.emit};
    assign counts_in_range = (int'(linear_count) <= dpht_pkg::TABLE_SIZE)
                          && (int'(quadratic_count) <= dpht_pkg::TABLE_SIZE);

    `DPHT_ASSERT(a_one_strobe, clk, rst_n, $onehot0(strobes), "multiple strobes")
    `DPHT_ASSERT(a_busy_after_accept, clk, rst_n, ctrl.accept |=> in_stall, "taken while busy")
    `DPHT_ASSERT(a_emit_valid, clk, rst_n, ctrl.emit |=> out_valid, "result not presented")
    `DPHT_NEVER(a_emit_overwrite, clk, rst_n, ctrl.emit && out_valid_reg && out_stall, "overwrite")
    `DPHT_ASSERT(a_count_range, clk, rst_n, out_valid |-> counts_in_range, "count too large")

endmodule

// ===== src/dpht_seq.sv =====
// Microcode sequencer: step counter, control ROM from dpht_pkg, jump logic.
// Depends on dpht_pkg.
`timescale 1ns / 1ps

module dpht_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                probes_done,
    input  logic                out_free,
    output logic                in_stall,
    output dpht_pkg::seq_ctrl_t ctrl
);

    dpht_pkg::upc_t   upc_reg;
    dpht_pkg::upc_t   upc_next;
    dpht_pkg::ucode_t cw;
    logic             cond_met;

    always_comb
    begin
        cw = dpht_pkg::ucode_rom(upc_reg);
    end

    // strobes see only the handshake, so probes_done reaches upc_next alone
    always_comb
    begin
        ctrl.accept = cw.accept_act & in_valid;
        ctrl.probe  = cw.probe_act;
        ctrl.emit   = cw.emit_act & out_free;
        in_stall    = ~cw.accept_act;
    end

    always_comb
    begin
        case (cw.cond)
            dpht_pkg::COND_IN_VALID: cond_met = in_valid;
            dpht_pkg::COND_DONE:     cond_met = probes_done;
            dpht_pkg::COND_OUT_FREE: cond_met = out_free;
            default:                 cond_met = 1'b1;
        endcase
        upc_next = cond_met ? cw.target : upc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= dpht_pkg::UPC_ACCEPT;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

// ===== src/dpht_probe.sv =====
// One open-addressing key table with its probe unit; linear or quadratic stepping.
// Depends on dpht_pkg.
`timescale 1ns / 1ps

module dpht_probe (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          quad,
    input  dpht_pkg::seq_ctrl_t           ctrl,
    input  logic                          search,
    input  logic [dpht_pkg::KEY_BITS-1:0] in_key,
    input  logic [dpht_pkg::KEY_BITS-1:0] key_q,
    output dpht_pkg::probe_res_t          res
);

    localparam int SW = dpht_pkg::SLOT_W;
    localparam int JW = dpht_pkg::STEP_W;
    localparam int CW = dpht_pkg::COUNT_W;

    logic [dpht_pkg::KEY_BITS-1:0] keys_mem [dpht_pkg::TABLE_SIZE];
    logic [dpht_pkg::KEY_BITS-1:0] rd_key_reg;
    logic [dpht_pkg::TABLE_SIZE-1:0] valid_reg, valid_next;

    logic [SW-1:0]    slot_reg, slot_next;
    logic [JW-1:0]    j_reg, j_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;
    dpht_pkg::status_t status_reg, status_next;

    logic [2*JW-1:0]  j_sq;
    logic [SW-1:0]    step_add;
    logic [CW-1:0]    cnt_inc;
    logic             slot_valid;
    logic             wr_en;

    always_comb
    begin
        j_sq        = (2*JW)'(j_reg) * (2*JW)'(j_reg);
        step_add    = quad ? j_sq[SW-1:0] : SW'(1);
        cnt_inc     = (cnt_reg == dpht_pkg::COUNT_MAX) ? cnt_reg : cnt_reg + CW'(1);
        slot_valid  = valid_reg[slot_reg];
        slot_next   = slot_reg;
        j_next      = j_reg;
        cnt_next    = cnt_reg;
        done_next   = done_reg;
        status_next = status_reg;
        valid_next  = valid_reg;
        wr_en       = 1'b0;
        if (ctrl.accept)
        begin
            slot_next = in_key[SW-1:0];
            j_next    = JW'(1);
            cnt_next  = '0;
            done_next = 1'b0;
        end
        else if (ctrl.probe && !done_reg)
        begin
            if (!slot_valid)
            begin
                done_next = 1'b1;
                if (search)
                begin
                    status_next = dpht_pkg::ST_NOT_FOUND;
                end
                else
                begin
                    status_next          = dpht_pkg::ST_OK;
                    cnt_next             = cnt_inc;
                    wr_en                = 1'b1;
                    valid_next[slot_reg] = 1'b1;
                end
            end
            else
            begin
                cnt_next = cnt_inc;
                if (search && rd_key_reg == key_q)
                begin
                    done_next   = 1'b1;
                    status_next = dpht_pkg::ST_OK;
                end
                else if (j_reg == JW'(dpht_pkg::TABLE_SIZE))
                begin
                    done_next   = 1'b1;
                    status_next = search ? dpht_pkg::ST_NOT_FOUND : dpht_pkg::ST_FULL;
                end
                else
                begin
                    slot_next = slot_reg + step_add;
                    j_next    = j_reg + JW'(1);
                end
            end
        end
        res.done_next = done_next;
        res.status    = status_reg;
        res.count     = cnt_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            done_reg   <= 1'b1;
            status_reg <= dpht_pkg::ST_OK;
            cnt_reg    <= '0;
            slot_reg   <= '0;
            j_reg      <= '0;
        end
        else
        begin
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            status_reg <= status_next;
            cnt_reg    <= cnt_next;
            slot_reg   <= slot_next;
            j_reg      <= j_next;
        end
    end

    // read address follows slot_next, so the data lines up with slot_reg
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            keys_mem[slot_reg] <= key_q;
        end
        rd_key_reg <= keys_mem[slot_next];
    end

endmodule
